FILE: hdl/miner_result_frame_decoder_assert.svh
// Assertion macros for the miner result frame decoder.
// Used by the top level only; depends on nothing else.
`ifndef MINER_RESULT_FRAME_DECODER_ASSERT_SVH
`define MINER_RESULT_FRAME_DECODER_ASSERT_SVH

`define MRFD_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`define MRFD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/mrfd_pkg.sv
// Types and constants shared by the miner result frame decoder.
// No dependencies.
package mrfd_pkg;

  localparam int FRAME_BYTES = 9;
  localparam int STORE_DEPTH = 8;
  localparam int STORE_IDX_W = $clog2(STORE_DEPTH);
  localparam int COUNT_W = 4;

  localparam logic [7:0] PREAMBLE_0 = 8'hAA;
  localparam logic [7:0] PREAMBLE_1 = 8'h55;

  localparam int ROLL_LSB = 13;
  localparam int ROLL_MSB = 28;
  localparam int ROLL_W = ROLL_MSB - ROLL_LSB + 1;

  localparam logic MODE_BYTE = 1'b0;
  localparam logic MODE_TIMEOUT = 1'b1;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_BAD_PREAMBLE = 2'd1;
  localparam logic [1:0] ST_SHORT = 2'd2;

  typedef struct packed {
    logic [1:0] status;
    logic [5:0] job_id;
    logic [1:0] midstate_index;
    logic [31:0] nonce;
    logic [31:0] midstate_version;
  } result_t;

endpackage

FILE: hdl/mrfd_if.sv
// Handshake channels of the miner result frame decoder: received words,
// decoded results and the base version write. No dependencies.
interface mrfd_in_if;
  logic valid;
  logic ready;
  logic mode;
  logic [7:0] rx_byte;
  modport source (output valid, mode, rx_byte, input ready);
  modport sink (input valid, mode, rx_byte, output ready);
endinterface

interface mrfd_out_if;
  logic valid;
  logic ready;
  logic [1:0] status;
  logic [5:0] job_id;
  logic [1:0] midstate_index;
  logic [31:0] nonce;
  logic [31:0] midstate_version;
  modport source (output valid, status, job_id, midstate_index, nonce, midstate_version,
                  input ready);
  modport sink (input valid, status, job_id, midstate_index, nonce, midstate_version,
                output ready);
endinterface

interface mrfd_cfg_if;
  logic valid;
  logic ready;
  logic [31:0] base_version;
  modport source (output valid, base_version, input ready);
  modport sink (input valid, base_version, output ready);
endinterface

FILE: hdl/mrfd_collect.sv
// Input register, frame store, byte counter and frame decode.
// Depends on mrfd_pkg.
module mrfd_collect (
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  logic              mode,
  input  logic [7:0]        rx_byte,
  input  logic              space,
  input  logic [31:0]       base_version,
  output logic              busy,
  output logic              push,
  output mrfd_pkg::result_t res
);
  import mrfd_pkg::*;

  logic                 s1_valid;
  logic                 s1_mode;
  logic [7:0]           s1_byte;
  logic [COUNT_W-1:0]   count;
  logic [COUNT_W-1:0]   count_next;
  logic [7:0]           store [STORE_DEPTH];
  logic                 drain;
  logic [ROLL_W-1:0]    field;

  assign drain = s1_valid && space;
  assign busy = s1_valid;
  assign field = base_version[ROLL_MSB:ROLL_LSB] + ROLL_W'(store[7][1:0]);

  always_comb begin
    push = 1'b0;
    res = '0;
    count_next = count;
    if (drain) begin
      if (s1_mode == MODE_TIMEOUT) begin
        if (count != '0) begin
          push = 1'b1;
          res.status = ST_SHORT;
          count_next = '0;
        end
      end else if (count == COUNT_W'(FRAME_BYTES - 1)) begin
        push = 1'b1;
        count_next = '0;
        if (store[0] != PREAMBLE_0 || store[1] != PREAMBLE_1) begin
          res.status = ST_BAD_PREAMBLE;
        end else begin
          res.status = ST_OK;
          res.job_id = store[7][7:2];
          res.midstate_index = store[7][1:0];
          res.nonce = {store[5], store[4], store[3], store[2]};
          res.midstate_version = {base_version[31:ROLL_MSB+1], field,
                                  base_version[ROLL_LSB-1:0]};
        end
      end else begin
        count_next = count + COUNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      count <= '0;
    end else begin
      count <= count_next;
      if (take) begin
        s1_valid <= 1'b1;
      end else if (drain) begin
        s1_valid <= 1'b0;
      end
    end
    if (take) begin
      s1_mode <= mode;
      s1_byte <= rx_byte;
    end
    if (drain && s1_mode == MODE_BYTE && count < COUNT_W'(STORE_DEPTH)) begin
      store[count[STORE_IDX_W-1:0]] <= s1_byte;
    end
  end

endmodule

FILE: hdl/mrfd_outq.sv
// Two-entry result queue between the decode and the result channel.
// Depends on mrfd_pkg.
module mrfd_outq (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  mrfd_pkg::result_t din,
  output logic              space,
  output logic              empty,
  output logic              valid,
  output mrfd_pkg::result_t dout,
  input  logic              ready
);
  import mrfd_pkg::*;

  result_t    slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       pop;

  assign valid = (fill != 2'd0);
  assign empty = (fill == 2'd0);
  assign space = (fill != 2'd2);
  assign pop = valid && ready;
  assign dout = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
    if (push) begin
      slots[wr_ptr] <= din;
    end
  end

endmodule

FILE: hdl/miner_result_frame_decoder.sv
// Top level of the miner result frame decoder.
// Depends on mrfd_pkg, mrfd_if.sv, mrfd_collect, mrfd_outq and the assertion header.
//
//   Channel  Role   Moves
//   rx       sink   one received byte or a read window timeout per word
//   result   source one decoded frame status per word
//   cfg      sink   base version write, ready whenever out of reset
//
// A word is taken in every cycle while the result queue has room.
// A result is offered after its word has passed the input register and been written into the result queue.
// Reset clears the byte count, the input register and the result queue.
// A stalled result channel stops intake once the two-entry result queue is full
// and a word waits in the input register.
`include "miner_result_frame_decoder_assert.svh"

module miner_result_frame_decoder (
  input  logic clk,
  input  logic rst,
  mrfd_in_if.sink     rx,
  mrfd_out_if.source  result,
  mrfd_cfg_if.sink    cfg
);
  import mrfd_pkg::*;

  logic [31:0] base_version;
  logic        busy;
  logic        space;
  logic        empty;
  logic        push;
  logic        take;
  logic        q_valid;
  result_t     res;
  result_t     q_dout;

  assign cfg.ready = !rst;
  assign rx.ready = !rst && (!busy || space);
  assign take = rx.valid && rx.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_version <= '0;
    end else if (cfg.valid) begin
      base_version <= cfg.base_version;
    end
  end

  mrfd_collect u_collect (
    .clk          (clk),
    .rst          (rst),
    .take         (take),
    .mode         (rx.mode),
    .rx_byte      (rx.rx_byte),
    .space        (space),
    .base_version (base_version),
    .busy         (busy),
    .push         (push),
    .res          (res)
  );

  mrfd_outq u_outq (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (res),
    .space (space),
    .empty (empty),
    .valid (q_valid),
    .dout  (q_dout),
    .ready (result.ready)
  );

  assign result.valid = q_valid;
  assign result.status = q_dout.status;
  assign result.job_id = q_dout.job_id;
  assign result.midstate_index = q_dout.midstate_index;
  assign result.nonce = q_dout.nonce;
  assign result.midstate_version = q_dout.midstate_version;

  `MRFD_ASSERT_NEXT(a_push_shows, clk, rst, push && empty, result.valid,
                    "Result pushed into an empty queue did not appear.")
  `MRFD_ASSERT_SAME(a_short_clear, clk, rst, result.valid && result.status == ST_SHORT,
                    result.nonce == '0 && result.job_id == '0 &&
                    result.midstate_index == '0 && result.midstate_version == '0,
                    "Short frame result carries payload.")
  `MRFD_ASSERT_SAME(a_take_lands, clk, rst, push, busy && space,
                    "Result pushed without a word in the input register and queue room.")

endmodule
